// ----- hw/rtl/pbat_pkg.sv -----
package pbat_pkg;

    // block size in bytes, a power of two
    localparam int BLOCK_SIZE  = 16384;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_SIZE);

    // default block count limit
    localparam int MAX_BLOCKS_DEF = 64;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int OFF_W   = 32;
    localparam int LEN_W   = 32;
    localparam int PSZ_W   = 21;
    localparam logic [PSZ_W-1:0] PIECE_SIZE_RST = PSZ_W'(1048576);

    // block index of an offset, block count of a length
    localparam int START_W = OFF_W - BLOCK_SHIFT;
    localparam int NBLK_W  = LEN_W + 1 - BLOCK_SHIFT;

    // item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_RECV    = 2'd0,
        FUNC_QUERY   = 2'd1,
        FUNC_RELEASE = 2'd2
    } func_t;

    // state update from the evaluator
    typedef struct packed {
        logic set_en;
        logic release_en;
    } upd_t;

endpackage

// ----- hw/rtl/pbat_map_store.sv -----
module pbat_map_store
    import pbat_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  piece_size_we,
    input  logic [PSZ_W-1:0]      piece_size,
    input  upd_t                  upd,
    input  logic [MAX_BLOCKS-1:0] set_mask,
    output logic [MAX_BLOCKS-1:0] map_valid,
    output logic [PSZ_W-1:0]      piece_size_q,
    output logic                  released
);

    localparam int CNT_W = PSZ_W + 1 - BLOCK_SHIFT;

    logic [MAX_BLOCKS-1:0] map_reg;
    logic [MAX_BLOCKS-1:0] map_next;
    logic [PSZ_W-1:0]      piece_size_reg;
    logic                  released_reg;
    logic                  released_next;
    logic [CNT_W-1:0]      blk_cnt;
    logic [MAX_BLOCKS-1:0] in_piece;

    // block count of the piece, rounded up
    assign blk_cnt = CNT_W'(({1'b0, piece_size_reg} + (PSZ_W + 1)'(BLOCK_SIZE - 1))
                     >> BLOCK_SHIFT);

    // blocks inside the piece; the clip to MAX_BLOCKS follows from the mask width
    always_comb
    begin
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            in_piece[i] = (CNT_W + 7)'(i) < (CNT_W + 7)'(blk_cnt);
        end
    end

    // next bitmap and release flag, sets clipped to the piece
    always_comb
    begin
        map_next      = map_reg;
        released_next = released_reg;
        if (piece_size_we)
        begin
            map_next = '0;
        end
        else if (upd.set_en)
        begin
            map_next = map_reg | (set_mask & in_piece);
        end
        if (upd.release_en)
        begin
            released_next = 1'b1;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg        <= '0;
            piece_size_reg <= PIECE_SIZE_RST;
            released_reg   <= 1'b0;
        end
        else
        begin
            map_reg      <= map_next;
            released_reg <= released_next;
            if (piece_size_we)
            begin
                piece_size_reg <= piece_size;
            end
        end
    end

    assign map_valid    = map_reg & in_piece;
    assign piece_size_q = piece_size_reg;
    assign released     = released_reg;

    // release is sticky
    a_release_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        released_reg |=> released_reg)
        else $error("release flag dropped");

    // a size write clears the bitmap
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        piece_size_we |=> (map_reg == '0))
        else $error("bitmap not cleared by size write");

    // no block past the piece end is ever marked
    a_map_in_piece: assert property (@(posedge clk) disable iff (!rst_n)
        (map_reg & ~in_piece) == '0)
        else $error("block marked outside the piece");

endmodule

// ----- hw/rtl/pbat_eval.sv -----
module pbat_eval
    import pbat_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                  item_vld,
    input  logic [FUNC_W-1:0]     func,
    input  logic [OFF_W-1:0]      byte_offset,
    input  logic [LEN_W-1:0]      byte_length,
    input  logic [MAX_BLOCKS-1:0] map_valid,
    input  logic [PSZ_W-1:0]      piece_size,
    input  logic                  released,
    output upd_t                  upd,
    output logic [MAX_BLOCKS-1:0] set_mask,
    output logic                  accepted,
    output logic [OFF_W-1:0]      avail_offset,
    output logic [PSZ_W-1:0]      avail_length
);

    localparam int RUN_W  = $clog2(MAX_BLOCKS + 1);
    localparam int SPAN_W = NBLK_W + 1;
    localparam int SUM_W  = OFF_W + 2;

    func_t                 fcode;
    logic [START_W-1:0]    start_blk;
    logic [NBLK_W-1:0]     nblk;
    logic [SPAN_W-1:0]     end_blk;
    logic                  recv_ok;
    logic [MAX_BLOCKS-1:0] shifted;
    logic [MAX_BLOCKS:0]   run_x;
    logic [MAX_BLOCKS:0]   first_zero;
    logic [MAX_BLOCKS:0]   run_mask;
    logic [RUN_W-1:0]      run_len;
    logic [NBLK_W-1:0]     ind;
    logic [SUM_W-1:0]      run_bytes;
    logic [SUM_W-1:0]      run_end;
    logic [PSZ_W-1:0]      q_len;

    assign fcode = func_t'(func);

    // block index and rounded-up block count
    assign start_blk = START_W'(byte_offset >> BLOCK_SHIFT);
    assign nblk      = NBLK_W'(({1'b0, byte_length} + (LEN_W + 1)'(BLOCK_SIZE - 1))
                       >> BLOCK_SHIFT);
    assign end_blk   = SPAN_W'(start_blk) + SPAN_W'(nblk);

    // receive fits inside the piece and the piece is not released
    assign recv_ok = !released &&
                     (({1'b0, byte_offset} + {1'b0, byte_length}) <=
                      (OFF_W + 1)'(piece_size));

    // blocks covered by the receive, the store clips them to the piece
    always_comb
    begin
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            set_mask[i] = (SPAN_W'(i) >= SPAN_W'(start_blk)) &&
                          (SPAN_W'(i) < end_blk);
        end
    end

    // run of available blocks from the start block
    assign shifted    = MAX_BLOCKS'(map_valid >> start_blk);
    assign run_x      = {1'b0, shifted};
    assign first_zero = ~run_x & (run_x + (MAX_BLOCKS + 1)'(1));
    assign run_mask   = first_zero - (MAX_BLOCKS + 1)'(1);
    assign run_len    = RUN_W'($countones(run_mask));

    // blocks reported, bytes they span
    always_comb
    begin
        if (released || (NBLK_W'(run_len) >= nblk))
        begin
            ind = nblk;
        end
        else
        begin
            ind = NBLK_W'(run_len);
        end
    end

    assign run_bytes = SUM_W'({ind, {BLOCK_SHIFT{1'b0}}});
    assign run_end   = SUM_W'(byte_offset) + run_bytes;

    // clip the run at the piece end, saturating at zero
    always_comb
    begin
        if (ind == '0)
        begin
            q_len = '0;
        end
        else if (run_end > SUM_W'(piece_size))
        begin
            if (OFF_W'(piece_size) > byte_offset)
            begin
                q_len = piece_size - PSZ_W'(byte_offset);
            end
            else
            begin
                q_len = '0;
            end
        end
        else
        begin
            q_len = PSZ_W'(run_bytes);
        end
    end

    // result fields and state update by function
    always_comb
    begin
        upd          = '0;
        accepted     = 1'b0;
        avail_offset = '0;
        avail_length = '0;
        case (fcode)
            FUNC_RECV:
            begin
                accepted   = recv_ok;
                upd.set_en = item_vld && recv_ok;
            end
            FUNC_QUERY:
            begin
                avail_length = q_len;
                avail_offset = (q_len != '0) ? byte_offset : '0;
            end
            FUNC_RELEASE:
            begin
                upd.release_en = item_vld;
            end
            default:
            begin
                upd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/piece_block_availability_tracker_unit.sv -----
// channel    | handshake               | ports
// -----------+-------------------------+---------------------------------------
// item in    | start && !busy          | func, byte_offset, byte_length
// result out | done (one-cycle strobe) | accepted, avail_offset, avail_length
// config     | piece_size_we           | piece_size
//
// an item is taken into the input register on the accepting edge; the bitmap
// logic evaluates it in the next cycle and done strobes in the cycle after that
// one item per cycle, busy never rises
// the bitmap update lands together with the result, so the following item
// sees it; rst_n clears the bitmap and the release flag and sets the default size
// the receiver cannot stall, each result shows for exactly one cycle
module piece_block_availability_tracker_unit
    import pbat_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] func,
    input  logic [OFF_W-1:0]  byte_offset,
    input  logic [LEN_W-1:0]  byte_length,
    input  logic              piece_size_we,
    input  logic [PSZ_W-1:0]  piece_size,
    output logic              done,
    output logic              accepted,
    output logic [OFF_W-1:0]  avail_offset,
    output logic [PSZ_W-1:0]  avail_length
);

    logic                  item_vld_reg;
    logic [FUNC_W-1:0]     func_reg;
    logic [OFF_W-1:0]      off_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  done_reg;
    logic                  accepted_reg;
    logic [OFF_W-1:0]      avail_offset_reg;
    logic [PSZ_W-1:0]      avail_length_reg;
    logic                  accepted_next;
    logic [OFF_W-1:0]      avail_offset_next;
    logic [PSZ_W-1:0]      avail_length_next;
    upd_t                  upd;
    logic [MAX_BLOCKS-1:0] set_mask;
    logic [MAX_BLOCKS-1:0] map_valid;
    logic [PSZ_W-1:0]      piece_size_q;
    logic                  released;
    logic                  take;

    assign busy = 1'b0;
    assign take = start && !busy;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else
        begin
            item_vld_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg <= func;
            off_reg  <= byte_offset;
            len_reg  <= byte_length;
        end
    end

    // bitmap, size and release flag
    pbat_map_store #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .piece_size_we (piece_size_we),
        .piece_size    (piece_size),
        .upd           (upd),
        .set_mask      (set_mask),
        .map_valid     (map_valid),
        .piece_size_q  (piece_size_q),
        .released      (released)
    );

    // per-item evaluation
    pbat_eval #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_eval (
        .item_vld     (item_vld_reg),
        .func         (func_reg),
        .byte_offset  (off_reg),
        .byte_length  (len_reg),
        .map_valid    (map_valid),
        .piece_size   (piece_size_q),
        .released     (released),
        .upd          (upd),
        .set_mask     (set_mask),
        .accepted     (accepted_next),
        .avail_offset (avail_offset_next),
        .avail_length (avail_length_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= item_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_vld_reg)
        begin
            accepted_reg     <= accepted_next;
            avail_offset_reg <= avail_offset_next;
            avail_length_reg <= avail_length_next;
        end
    end

    assign done         = done_reg;
    assign accepted     = accepted_reg;
    assign avail_offset = avail_offset_reg;
    assign avail_length = avail_length_reg;

    // every taken item gives a result, through the input and result registers
    a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> ##1 done)
        else $error("item without result");

    // no result without an item
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(item_vld_reg))
        else $error("result without item");

    // a recorded receive carries no run
    a_recv_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && accepted) |-> (avail_offset == '0 && avail_length == '0))
        else $error("receive result carries a run");

endmodule
